// ===== src/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Types and constants shared by the keyed record table blocks.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int TEXT_W    = 64;
	localparam int MAX_BYTES = 8;
	localparam int SLOT_W    = 6;
	localparam int Q_DEPTH   = 2;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_LIST   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_DELETED  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_RECORD   = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [TEXT_W-1:0] key_word;
		logic [TEXT_W-1:0] second_word;
		logic [TEXT_W-1:0] phone_word;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [TEXT_W-1:0] out_key;
		logic [TEXT_W-1:0] out_second;
		logic [TEXT_W-1:0] out_phone;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} out_item_t;

	// request after text narrowing, as held in the command queue
	typedef struct packed {
		kind_t             kind;
		logic              key_nz;
		logic [TEXT_W-1:0] key;
		logic [TEXT_W-1:0] second;
		logic [TEXT_W-1:0] phone;
	} cmd_t;

endpackage

// ===== src/keyed_record_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Linear-search record table: add, delete, search and list requests.
// ----------------------------------------------------------------------------
// An add is handled at once in the execution stage and gives one result. Delete,
// search and list walk the slots below the fill count one per cycle through
// the single read port of the record memories, and hold the execution stage
// while they do; a search or list walk can wait while the result side stalls,
// and a delete stops at its first match. A delete or search with an empty
// key, or any scan of an empty table, answers at once without a scan. Requests
// are narrowed and queued up to two deep ahead of the execution stage, so new
// requests are taken while a scan runs. Search and list results come out in
// slot order, last set on the final one.
module keyed_record_table_unit #(
	parameter int DEPTH      = 64,
	parameter int TEXT_BYTES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  krt_pkg::in_item_t  req,
	input  logic               req_valid,
	output logic               req_ready,
	output krt_pkg::out_item_t rsp,
	output logic               rsp_valid,
	input  logic               rsp_ready
);
	import krt_pkg::*;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;

	krt_front #(
		.TEXT_BYTES(TEXT_BYTES)
	) u_front (
		.req      (req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd      (front_cmd),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready)
	);

	krt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cmd  (front_cmd),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.pop_cmd   (q_cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready)
	);

	krt_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (q_cmd),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

// ===== src/krt_front.sv =====
// ----------------------------------------------------------------------------
// krt_front
// Request intake: cuts each text word at its first zero byte and at the
// configured byte count, and flags an empty key.
// ----------------------------------------------------------------------------
module krt_front #(
	parameter int TEXT_BYTES = 8
) (
	input  krt_pkg::in_item_t req,
	input  logic              req_valid,
	output logic              req_ready,
	output krt_pkg::cmd_t     cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready
);
	import krt_pkg::*;

	function automatic logic [TEXT_W-1:0] narrow(input logic [TEXT_W-1:0] w);
		logic [TEXT_W-1:0] r;
		logic              stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (w[8*i +: 8] == 8'd0 || i >= TEXT_BYTES) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[8*i +: 8] = w[8*i +: 8];
			end
		end
		return r;
	endfunction

	logic [TEXT_W-1:0] key_n;

	assign key_n      = narrow(req.key_word);
	assign cmd.kind   = req.kind;
	assign cmd.key    = key_n;
	assign cmd.key_nz = (key_n != '0);
	assign cmd.second = narrow(req.second_word);
	assign cmd.phone  = narrow(req.phone_word);
	assign cmd_valid  = req_valid;
	assign req_ready  = cmd_ready;

endmodule

// ===== src/krt_queue.sv =====
// ----------------------------------------------------------------------------
// krt_queue
// Short command queue between request intake and table execution.
// ----------------------------------------------------------------------------
module krt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  krt_pkg::cmd_t push_cmd,
	input  logic          push_valid,
	output logic          push_ready,
	output krt_pkg::cmd_t pop_cmd,
	output logic          pop_valid,
	input  logic          pop_ready
);
	import krt_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int NW = $clog2(Q_DEPTH + 1);

	cmd_t          entry_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != NW'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/krt_back.sv =====
// ----------------------------------------------------------------------------
// krt_back
// Table execution: record memories, fill count, slot scan and result
// output register.
// ----------------------------------------------------------------------------
module krt_back #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  krt_pkg::cmd_t      cmd,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	output krt_pkg::out_item_t rsp,
	output logic               rsp_valid,
	input  logic               rsp_ready
);
	import krt_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	back_state_t       state_q;
	back_state_t       state_d;
	cmd_t              cur_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     idx_d;
	logic [CW-1:0]     fill_q;
	out_item_t         pend_q;
	logic              pend_valid_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [TEXT_W-1:0] key_mem [DEPTH];
	logic [TEXT_W-1:0] sec_mem [DEPTH];
	logic [TEXT_W-1:0] ph_mem  [DEPTH];
	logic [TEXT_W-1:0] rkey_q;
	logic [TEXT_W-1:0] rsec_q;
	logic [TEXT_W-1:0] rph_q;

	logic              we;
	logic [IW-1:0]     waddr;
	logic [IW-1:0]     raddr;
	logic [TEXT_W-1:0] wkey;
	logic [TEXT_W-1:0] wsec;
	logic [TEXT_W-1:0] wph;
	logic              out_free;
	logic              emit;
	out_item_t         emit_item;
	logic              pend_load;
	logic              pend_clear;
	out_item_t         pend_item;
	out_item_t         rec_item;
	logic              cur_load;
	logic              fill_inc;
	logic              hit;
	logic              last_slot;
	logic              adv;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;
	assign last_slot = ((CW'(idx_q) + CW'(1)) == fill_q);

	always_comb begin
		rec_item            = '0;
		rec_item.status     = ST_RECORD;
		rec_item.out_key    = rkey_q;
		rec_item.out_second = rsec_q;
		rec_item.out_phone  = rph_q;
		rec_item.slot       = SLOT_W'(idx_q);
	end

	always_comb begin
		unique case (cur_q.kind)
			KIND_LIST:   hit = (rkey_q != '0);
			KIND_SEARCH: hit = (rkey_q == cur_q.key);
			KIND_DELETE: hit = (rkey_q == cur_q.key);
			KIND_ADD:    hit = 1'b0;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		emit       = 1'b0;
		emit_item  = '0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		pend_item  = '0;
		we         = 1'b0;
		waddr      = idx_q;
		wkey       = '0;
		wsec       = '0;
		wph        = '0;
		raddr      = idx_q;
		idx_d      = idx_q;
		fill_inc   = 1'b0;
		cur_load   = 1'b0;
		adv        = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				raddr = '0;
				if (cmd_valid) begin
					if (cmd.kind == KIND_ADD) begin
						if (out_free) begin
							cmd_ready      = 1'b1;
							emit           = 1'b1;
							emit_item.last = 1'b1;
							if (fill_q == CW'(DEPTH)) begin
								emit_item.status = ST_FULL;
							end else begin
								we               = 1'b1;
								waddr            = fill_q[IW-1:0];
								wkey             = cmd.key;
								wsec             = cmd.second;
								wph              = cmd.phone;
								emit_item.status = ST_ADDED;
								emit_item.slot   = SLOT_W'(fill_q);
								fill_inc         = 1'b1;
							end
						end
					end else if (fill_q == '0 || (cmd.kind != KIND_LIST && !cmd.key_nz)) begin
						// nothing to scan: answer at once
						if (out_free) begin
							cmd_ready        = 1'b1;
							emit             = 1'b1;
							emit_item.last   = 1'b1;
							emit_item.status = (cmd.kind == KIND_LIST) ? ST_EMPTY : ST_NOTFOUND;
						end
					end else begin
						cmd_ready  = 1'b1;
						cur_load   = 1'b1;
						idx_d      = '0;
						pend_clear = 1'b1;
						state_d    = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				if (cur_q.kind == KIND_DELETE) begin
					if (hit) begin
						we               = 1'b1;
						waddr            = idx_q;
						pend_load        = 1'b1;
						pend_item.status = ST_DELETED;
						pend_item.slot   = SLOT_W'(idx_q);
						state_d          = BK_FINISH;
					end else if (last_slot) begin
						state_d = BK_FINISH;
					end else begin
						idx_d = idx_q + IW'(1);
						raddr = idx_d;
					end
				end else begin
					// a held hit goes out only when a newer one displaces it
					adv = !(hit && pend_valid_q) || out_free;
					if (adv) begin
						if (hit) begin
							pend_load = 1'b1;
							pend_item = rec_item;
							if (pend_valid_q) begin
								emit      = 1'b1;
								emit_item = pend_q;
							end
						end
						if (last_slot) begin
							state_d = BK_FINISH;
						end else begin
							idx_d = idx_q + IW'(1);
							raddr = idx_d;
						end
					end
				end
			end
			BK_FINISH: begin
				if (out_free) begin
					emit       = 1'b1;
					pend_clear = 1'b1;
					state_d    = BK_IDLE;
					if (pend_valid_q) begin
						emit_item      = pend_q;
						emit_item.last = 1'b1;
					end else begin
						emit_item.status = (cur_q.kind == KIND_LIST) ? ST_EMPTY : ST_NOTFOUND;
						emit_item.last   = 1'b1;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (fill_inc) begin
				fill_q <= fill_q + CW'(1);
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_load) begin
			cur_q <= cmd;
		end
		if (pend_load) begin
			pend_q <= pend_item;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			sec_mem[waddr] <= wsec;
			ph_mem[waddr]  <= wph;
		end
		rkey_q <= key_mem[raddr];
		rsec_q <= sec_mem[raddr];
		rph_q  <= ph_mem[raddr];
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond table depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CW'(1)))
		else $error("fill count moved by other than one");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (fill_q != '0 && CW'(idx_q) < fill_q))
		else $error("scan outside filled slots");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == BK_SCAN || state_q == BK_FINISH))
		else $error("held hit outside a scan");

endmodule

// ===== tb/keyed_record_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_record_table_unit_tb
// Self-checking bench for the record table: a shadow table predicts every
// response, directed requests cover the corner cases, then random traffic
// fills the table past capacity while both sides stall at random.
// ----------------------------------------------------------------------------
module keyed_record_table_unit_tb;
	import krt_pkg::*;

	localparam int DEPTH       = 64;
	localparam int TEXT_BYTES  = 8;
	localparam int POOL_SIZE   = 16;
	localparam int IDLE_LIMIT  = 3000;
	localparam int SETTLE      = 100;
	localparam int MAX_REPORTS = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	in_item_t  req       = '0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	out_item_t rsp;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;

	// shadow copy of the table contents
	logic [TEXT_W-1:0] shadow_key[DEPTH];
	logic [TEXT_W-1:0] shadow_second[DEPTH];
	logic [TEXT_W-1:0] shadow_phone[DEPTH];
	int                shadow_fill = 0;

	in_item_t          pending_req[$];
	out_item_t         expected_rsp[$];
	in_item_t          next_req;
	logic [TEXT_W-1:0] key_pool[POOL_SIZE];

	int calm_left[2] = '{0, 0};
	int send_gap     = 0;
	int rcv_gap      = 0;
	int idle_cycles  = 0;
	int mismatches   = 0;
	int sent         = 0;
	int checked      = 0;
	int n_added      = 0;
	int n_full       = 0;
	int n_deleted    = 0;
	int n_notfound   = 0;
	int n_records    = 0;
	int n_empty      = 0;

	keyed_record_table_unit #(
		.DEPTH      (DEPTH),
		.TEXT_BYTES (TEXT_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	always #5 clk = ~clk;

	// c-string view of a word: stop at the first zero byte
	function automatic logic [TEXT_W-1:0] cut_text(logic [TEXT_W-1:0] w);
		logic [TEXT_W-1:0] r;
		r = '0;
		for (int i = 0; i < TEXT_BYTES; i++) begin
			if (w[8*i +: 8] == 8'h00)
				break;
			r[8*i +: 8] = w[8*i +: 8];
		end
		return r;
	endfunction

	function automatic void predict_table_response(in_item_t r);
		logic [TEXT_W-1:0] k;
		out_item_t         o;
		out_item_t         held;
		bit                have_held;
		bit                hit;
		k         = cut_text(r.key_word);
		o         = '0;
		o.last    = 1'b1;
		held      = '0;
		have_held = 1'b0;
		case (r.kind)
			KIND_ADD: begin
				if (shadow_fill >= DEPTH) begin
					o.status = ST_FULL;
					n_full++;
				end else begin
					shadow_key[shadow_fill]    = k;
					shadow_second[shadow_fill] = cut_text(r.second_word);
					shadow_phone[shadow_fill]  = cut_text(r.phone_word);
					o.status = ST_ADDED;
					o.slot   = SLOT_W'(shadow_fill);
					shadow_fill++;
					n_added++;
				end
				expected_rsp.push_back(o);
			end
			KIND_DELETE: begin
				o.status = ST_NOTFOUND;
				if (k != '0) begin
					for (int i = 0; i < shadow_fill; i++) begin
						if (shadow_key[i] == k) begin
							shadow_key[i]    = '0;
							shadow_second[i] = '0;
							shadow_phone[i]  = '0;
							o.status = ST_DELETED;
							o.slot   = SLOT_W'(i);
							break;
						end
					end
				end
				if (o.status == ST_DELETED)
					n_deleted++;
				else
					n_notfound++;
				expected_rsp.push_back(o);
			end
			default: begin
				// search and list; hold each record back so the final one gets last
				for (int i = 0; i < shadow_fill; i++) begin
					if (r.kind == KIND_SEARCH)
						hit = (k != '0) && (shadow_key[i] == k);
					else
						hit = (shadow_key[i] != '0);
					if (hit) begin
						if (have_held)
							expected_rsp.push_back(held);
						held            = '0;
						held.status     = ST_RECORD;
						held.out_key    = shadow_key[i];
						held.out_second = shadow_second[i];
						held.out_phone  = shadow_phone[i];
						held.slot       = SLOT_W'(i);
						have_held       = 1'b1;
						n_records++;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					expected_rsp.push_back(held);
				end else begin
					if (r.kind == KIND_SEARCH) begin
						o.status = ST_NOTFOUND;
						n_notfound++;
					end else begin
						o.status = ST_EMPTY;
						n_empty++;
					end
					expected_rsp.push_back(o);
				end
			end
		endcase
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		checked++;
		if (expected_rsp.size() == 0) begin
			if (mismatches < MAX_REPORTS)
				$display("unexpected result: status %0d slot %0d key %h last %0b",
					got.status, got.slot, got.out_key, got.last);
			mismatches++;
			return;
		end
		want = expected_rsp.pop_front();
		if (got.status !== want.status || got.out_key !== want.out_key ||
				got.out_second !== want.out_second || got.out_phone !== want.out_phone ||
				got.slot !== want.slot || got.last !== want.last) begin
			if (mismatches < MAX_REPORTS) begin
				$display("mismatch at result %0d", checked);
				$display("  expected: status %0d slot %0d key %h second %h phone %h last %0b",
					want.status, want.slot, want.out_key, want.out_second,
					want.out_phone, want.last);
				$display("  actual:   status %0d slot %0d key %h second %h phone %h last %0b",
					got.status, got.slot, got.out_key, got.out_second,
					got.out_phone, got.last);
			end
			mismatches++;
		end
	endfunction

	// mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int pick_gap(int side);
		int roll;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left[side] = 30;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [TEXT_W-1:0] random_text(int len);
		logic [TEXT_W-1:0] w;
		w = '0;
		for (int i = 0; i < len; i++)
			w[8*i +: 8] = 8'($urandom_range(1, 255));
		return w;
	endfunction

	// junk behind the terminating zero byte must be ignored
	function automatic logic [TEXT_W-1:0] add_tail(logic [TEXT_W-1:0] w);
		logic [TEXT_W-1:0] r;
		int                z;
		r = w;
		z = 8;
		for (int i = 0; i < 8; i++) begin
			if (w[8*i +: 8] == 8'h00) begin
				z = i;
				break;
			end
		end
		if ($urandom_range(0, 2) == 0)
			for (int i = z + 1; i < 8; i++)
				r[8*i +: 8] = 8'($urandom);
		return r;
	endfunction

	function automatic in_item_t random_request();
		in_item_t r;
		int       pick;
		pick          = $urandom_range(0, 99);
		r.second_word = {$urandom, $urandom};
		r.phone_word  = {$urandom, $urandom};
		if (pick < 8) begin
			r.kind     = kind_t'(2'($urandom_range(0, 3)));
			r.key_word = {$urandom, $urandom};
		end else begin
			if (pick < 38)
				r.kind = KIND_ADD;
			else if (pick < 58)
				r.kind = KIND_DELETE;
			else if (pick < 88)
				r.kind = KIND_SEARCH;
			else
				r.kind = KIND_LIST;
			if ($urandom_range(0, 19) == 0)
				r.key_word = add_tail('0);
			else
				r.key_word = add_tail(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
			if (r.kind == KIND_ADD) begin
				r.second_word = add_tail(random_text($urandom_range(0, 8)));
				r.phone_word  = add_tail(random_text($urandom_range(0, 8)));
			end
		end
		return r;
	endfunction

	function automatic void queue_request(kind_t k, logic [TEXT_W-1:0] key,
			logic [TEXT_W-1:0] sec, logic [TEXT_W-1:0] ph);
		in_item_t r;
		r.kind        = k;
		r.key_word    = key;
		r.second_word = sec;
		r.phone_word  = ph;
		pending_req.push_back(r);
	endfunction

	task automatic wait_for_drain();
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(negedge clk);
	endtask

	// driver: expectations are formed when a transaction is presented
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap  <= 0;
		end else if (!req_valid || req_ready) begin
			if (req_valid)
				sent++;
			if (send_gap > 0) begin
				send_gap  <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_req.size() > 0) begin
				next_req = pending_req.pop_front();
				predict_table_response(next_req);
				req       <= next_req;
				req_valid <= 1'b1;
				send_gap  <= pick_gap(0);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rcv_gap   <= 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (rcv_gap > 0) begin
				rcv_gap   <= rcv_gap - 1;
				rsp_ready <= 1'b0;
			end else begin
				if ((rsp_valid && rsp_ready) || $urandom_range(0, 15) == 0)
					rcv_gap <= pick_gap(1);
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = random_text($urandom_range(1, 8));

		// empty table
		queue_request(KIND_LIST, '0, '0, '0);
		queue_request(KIND_SEARCH, 64'h0000_0000_0000_4241, '0, '0);
		queue_request(KIND_DELETE, 64'h0000_0000_0000_4241, '0, '0);
		// all ones, an empty key (slot not live), a key with junk after its end
		queue_request(KIND_ADD, '1, '1, '1);
		queue_request(KIND_ADD, '0, 64'h0000_0000_0063_6261, 64'h0000_00FF_0000_3231);
		queue_request(KIND_ADD, 64'h1234_5600_0000_4241, '0, 64'h3938_3736_3534_3332);
		queue_request(KIND_SEARCH, '0, '0, '0);
		queue_request(KIND_SEARCH, 64'h9999_0000_0000_4241, '1, '1);
		queue_request(KIND_DELETE, '0, '0, '0);
		// duplicate key, so a search returns two records
		queue_request(KIND_ADD, 64'h0000_0000_0000_4241, 64'h8000_0000_0000_0001, '1);
		queue_request(KIND_SEARCH, 64'h0000_0000_0000_4241, '0, '0);
		queue_request(KIND_LIST, '1, '1, '1);
		queue_request(KIND_DELETE, 64'hAB00_0000_0000_4241, '0, '0);
		queue_request(KIND_SEARCH, 64'h0000_0000_0000_4241, '0, '0);
		queue_request(KIND_DELETE, 64'hFFFF_FFFF_FFFF_FF00, '0, '0);
		queue_request(KIND_DELETE, '1, '0, '0);
		queue_request(KIND_LIST, '0, '0, '0);
		queue_request(KIND_SEARCH, '1, '0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait_for_drain();
		for (int i = 0; i < 150; i++)
			pending_req.push_back(random_request());
		// hold off until every outstanding response is back
		wait_for_drain();
		for (int i = 0; i < 135; i++)
			pending_req.push_back(random_request());
		wait_for_drain();
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d requests: %0d added, %0d full, %0d deleted, %0d not found",
			sent, n_added, n_full, n_deleted, n_notfound);
		$display("%0d records emitted, %0d empty lists, %0d results checked, fill %0d of %0d",
			n_records, n_empty, checked, shadow_fill, DEPTH);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
src/krt_pkg.sv
src/krt_front.sv
src/krt_queue.sv
src/krt_back.sv
src/keyed_record_table_unit.sv
tb/keyed_record_table_unit_tb.sv
